// ----- rtl/pntr_pkg.sv -----
// Shared constants, types and handshake structs for the page number translation recycler.
package pntr_pkg;

    localparam int MAX_REAL_PAGES   = 2048;
    localparam int SHORT_PAGE_COUNT = 255;
    localparam int SLOT_COUNT       = 8;

    localparam int REAL_W  = 11;
    localparam int SLOT_W  = 3;
    localparam int SHORT_W = 8;
    localparam int CFG_W   = 13;

    localparam int R_AW  = $clog2(MAX_REAL_PAGES);
    localparam int S_AW  = $clog2(SHORT_PAGE_COUNT);
    localparam int TRY_W = $clog2(SHORT_PAGE_COUNT + 1);

    localparam logic [SHORT_W-1:0] NO_PAGE    = 8'hFF;
    localparam logic [SHORT_W-1:0] LAST_SHORT = SHORT_W'(SHORT_PAGE_COUNT - 1);
    localparam logic [CFG_W-1:0]   BIG_LOW    = 13'd257;
    localparam logic [CFG_W-1:0]   BIG_HIGH   = CFG_W'(MAX_REAL_PAGES);

    typedef logic [R_AW-1:0] t_raddr;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic clr_step;
        logic rd_r2s;
        logic hit_take;
        logic search_step;
        logic fetch;
        logic commit;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic big_mode;
        logic hit;
        logic take;
        logic out_free;
        logic clr_last;
    } t_sts;

endpackage

// ----- rtl/pntr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module pntr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pntr_ctrl.sv -----
// Controller state machine that sequences lookup, recycling search, write-back and table clearing.
module pntr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pntr_pkg::t_sts i_sts,
    output pntr_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;
    localparam logic [2:0] S_CLEAR  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE) && !i_cfg_we;
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_sts.big_mode ? S_LOOKUP : S_FINISH;
                end
            end
            S_LOOKUP: begin
                o_cmd.rd_r2s = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.hit) begin
                    o_cmd.hit_take = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_sts.take) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // A register write restarts the clearing pass.
        if (i_cfg_we) begin
            o_cmd   = '0;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/pntr_dp.sv -----
// Datapath with both translation tables, the recycle cursor, slot pins and the output register.
module pntr_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pntr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [pntr_pkg::REAL_W-1:0]    i_real_page,
    input  logic [pntr_pkg::SLOT_W-1:0]    i_slot,
    input  pntr_pkg::t_cmd                 i_cmd,
    output pntr_pkg::t_sts                 o_sts,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [pntr_pkg::SHORT_W-1:0]   o_short_page,
    output logic                           o_allocated,
    output logic [pntr_pkg::REAL_W-1:0]    o_evicted_real_page
);

    logic [pntr_pkg::CFG_W-1:0]   r_page_count;
    pntr_pkg::t_raddr             r_real;
    logic [pntr_pkg::SLOT_W-1:0]  r_slot;
    logic [pntr_pkg::SHORT_W-1:0] r_cursor;
    logic [pntr_pkg::TRY_W-1:0]   r_tries;
    logic [pntr_pkg::SHORT_W-1:0] r_victim;
    pntr_pkg::t_raddr             r_clr_idx;
    logic [pntr_pkg::SHORT_W-1:0] r_slot_pages [pntr_pkg::SLOT_COUNT];

    logic [pntr_pkg::SHORT_W-1:0] r_res_short;
    logic                         r_res_alloc;
    logic [pntr_pkg::REAL_W-1:0]  r_res_evict;

    logic                         r_out_valid;
    logic [pntr_pkg::SHORT_W-1:0] r_out_short;
    logic                         r_out_alloc;
    logic [pntr_pkg::REAL_W-1:0]  r_out_evict;

    logic                         w_r2s_we;
    pntr_pkg::t_raddr             w_r2s_waddr;
    logic [pntr_pkg::SHORT_W-1:0] w_r2s_wdata;
    logic [pntr_pkg::SHORT_W-1:0] w_r2s_rdata;

    logic                         w_s2r_we;
    logic [pntr_pkg::S_AW-1:0]    w_s2r_waddr;
    pntr_pkg::t_raddr             w_s2r_wdata;
    logic                         w_s2r_re;
    pntr_pkg::t_raddr             w_s2r_rdata;

    logic                         w_clr_low;
    logic                         w_pinned;
    logic                         w_take;
    logic [pntr_pkg::SHORT_W-1:0] w_cursor_next;

    // Clearing pass: entries below the short page count get identity in both tables.
    assign w_clr_low = int'(r_clr_idx) < pntr_pkg::SHORT_PAGE_COUNT;

    always_comb begin
        w_r2s_we    = i_cmd.clr_step || i_cmd.fetch || i_cmd.commit;
        w_r2s_waddr = r_real;
        w_r2s_wdata = r_victim;
        if (i_cmd.clr_step) begin
            w_r2s_waddr = r_clr_idx;
            w_r2s_wdata = w_clr_low ? pntr_pkg::SHORT_W'(r_clr_idx) : pntr_pkg::NO_PAGE;
        end else if (i_cmd.fetch) begin
            w_r2s_waddr = w_s2r_rdata;
            w_r2s_wdata = pntr_pkg::NO_PAGE;
        end
    end

    always_comb begin
        w_s2r_we    = (i_cmd.clr_step && w_clr_low) || i_cmd.commit;
        w_s2r_waddr = i_cmd.clr_step ? r_clr_idx[pntr_pkg::S_AW-1:0]
                                     : r_victim[pntr_pkg::S_AW-1:0];
        w_s2r_wdata = i_cmd.clr_step ? r_clr_idx : r_real;
    end

    assign w_s2r_re = i_cmd.search_step && w_take;

    pntr_ram #(
        .WIDTH (pntr_pkg::SHORT_W),
        .DEPTH (pntr_pkg::MAX_REAL_PAGES)
    ) u_r2s (
        .i_clk   (i_clk),
        .i_we    (w_r2s_we),
        .i_waddr (w_r2s_waddr),
        .i_wdata (w_r2s_wdata),
        .i_re    (i_cmd.rd_r2s),
        .i_raddr (r_real),
        .o_rdata (w_r2s_rdata)
    );

    pntr_ram #(
        .WIDTH (pntr_pkg::R_AW),
        .DEPTH (pntr_pkg::SHORT_PAGE_COUNT)
    ) u_s2r (
        .i_clk   (i_clk),
        .i_we    (w_s2r_we),
        .i_waddr (w_s2r_waddr),
        .i_wdata (w_s2r_wdata),
        .i_re    (w_s2r_re),
        .i_raddr (r_cursor[pntr_pkg::S_AW-1:0]),
        .o_rdata (w_s2r_rdata)
    );

    // A number is pinned while any slot holds it.
    always_comb begin
        w_pinned = 1'b0;
        for (int i = 0; i < pntr_pkg::SLOT_COUNT; i++) begin
            if (r_slot_pages[i] == r_cursor) begin
                w_pinned = 1'b1;
            end
        end
    end

    // After a full turn with every number pinned, the one under the cursor is taken anyway.
    assign w_take = !w_pinned || (r_tries == pntr_pkg::TRY_W'(pntr_pkg::SHORT_PAGE_COUNT));
    assign w_cursor_next = (r_cursor == pntr_pkg::LAST_SHORT) ? '0
                                                              : r_cursor + pntr_pkg::SHORT_W'(1);

    always_comb begin
        o_sts.big_mode = (r_page_count >= pntr_pkg::BIG_LOW)
                      && (r_page_count <= pntr_pkg::BIG_HIGH);
        o_sts.hit      = w_r2s_rdata < pntr_pkg::SHORT_W'(pntr_pkg::SHORT_PAGE_COUNT);
        o_sts.take     = w_take;
        o_sts.out_free = !r_out_valid || i_out_ready;
        o_sts.clr_last = r_clr_idx == pntr_pkg::t_raddr'(pntr_pkg::MAX_REAL_PAGES - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= '0;
            r_cursor     <= '0;
            r_clr_idx    <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < pntr_pkg::SLOT_COUNT; i++) begin
                r_slot_pages[i] <= pntr_pkg::NO_PAGE;
            end
        end else begin
            if (i_cfg_we) begin
                r_page_count <= i_cfg_data;
                r_cursor     <= '0;
                r_clr_idx    <= '0;
            end else begin
                if (i_cmd.clr_step) begin
                    r_clr_idx <= r_clr_idx + pntr_pkg::t_raddr'(1);
                end
                if (i_cmd.search_step) begin
                    r_cursor <= w_cursor_next;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < pntr_pkg::SLOT_COUNT; i++) begin
                    if (int'(r_slot) == i) begin
                        r_slot_pages[i] <= r_res_short;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_real      <= pntr_pkg::t_raddr'(i_real_page);
            r_slot      <= i_slot;
            r_tries     <= '0;
            r_res_short <= i_real_page[pntr_pkg::SHORT_W-1:0];
            r_res_alloc <= 1'b0;
            r_res_evict <= '0;
        end
        if (i_cmd.hit_take) begin
            r_res_short <= w_r2s_rdata;
        end
        if (i_cmd.search_step) begin
            if (w_take) begin
                r_victim <= r_cursor;
            end else begin
                r_tries <= r_tries + pntr_pkg::TRY_W'(1);
            end
        end
        if (i_cmd.fetch) begin
            r_res_evict <= pntr_pkg::REAL_W'(w_s2r_rdata);
        end
        if (i_cmd.commit) begin
            r_res_short <= r_victim;
            r_res_alloc <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_out_short <= r_res_short;
            r_out_alloc <= r_res_alloc;
            r_out_evict <= r_res_evict;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_short_page        = r_out_short;
    assign o_allocated         = r_out_alloc;
    assign o_evicted_real_page = r_out_evict;

    a_finish_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("result beat not presented after finish");

    a_alloc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_alloc)
            |-> (r_out_short < pntr_pkg::SHORT_W'(pntr_pkg::SHORT_PAGE_COUNT)))
        else $error("recycled short page out of range");

    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_alloc) |-> (r_out_evict == '0))
        else $error("evicted page nonzero without allocation");

    a_clear_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_step |-> !(i_cmd.load_in || i_cmd.fetch || i_cmd.commit))
        else $error("table write collides with clearing pass");

endmodule

// ----- rtl/page_number_translation_recycler_unit.sv -----
// Top level of the page number translation recycler: controller plus datapath.
//
// The block maps an 11-bit real page number to an 8-bit short page number for a bank slot.
// Input beats (i_real_page, i_slot) arrive on i_in_valid / o_in_ready; result beats
// (o_short_page, o_allocated, o_evicted_real_page) leave on o_out_valid / i_out_ready.
// The page_count register is written through i_cfg_we / i_cfg_data; the user must do so
// only while idle, since the block itself does not enforce it.
// The controller works on one item at a time, stepping through table read, cursor
// search and write-back. In pass-through mode an accepted beat goes straight to the
// final step; on a hit the table read is checked first; on a recycle the cursor skips
// pinned short numbers (at most one per slot), then the evicted real page is fetched
// and both tables are written. The next input beat is accepted only once the previous
// item has finished. The cursor loop checks one number per cycle against all slot pins.
//
// After reset, and after every page_count write, a clearing pass writes identity into
// both translation tables; no input beat is accepted meanwhile.
// The result sits in an output register, so a stalled receiver holds the result beat
// while the next input beat is still accepted; that item then waits in its final step
// until the output register frees up.
module page_number_translation_recycler_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pntr_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pntr_pkg::REAL_W-1:0]  i_real_page,
    input  logic [pntr_pkg::SLOT_W-1:0]  i_slot,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pntr_pkg::SHORT_W-1:0] o_short_page,
    output logic                         o_allocated,
    output logic [pntr_pkg::REAL_W-1:0]  o_evicted_real_page
);

    // Command and status buses are the only link between controller and datapath.
    pntr_pkg::t_cmd w_cmd;
    pntr_pkg::t_sts w_sts;

    pntr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath latches the input beat on load_in, so the payload is sampled at accept.
    pntr_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_real_page         (i_real_page),
        .i_slot              (i_slot),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_short_page        (o_short_page),
        .o_allocated         (o_allocated),
        .o_evicted_real_page (o_evicted_real_page)
    );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the page number translation recycler unit.
`timescale 1ns / 1ps

module tb_top;

    // One translation result as it leaves the block.
    typedef struct packed {
        logic [pntr_pkg::SHORT_W-1:0] short_page;
        logic                         allocated;
        logic [pntr_pkg::REAL_W-1:0]  evicted;
    } t_page_result;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICTED,
        ROW_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind                    kind;
        logic [pntr_pkg::CFG_W-1:0]   cfg_value;
        logic [pntr_pkg::REAL_W-1:0]  real_pg;
        logic [pntr_pkg::SLOT_W-1:0]  slot_no;
        logic [pntr_pkg::SHORT_W-1:0] exp_short;
        logic                         exp_alloc;
        logic [pntr_pkg::REAL_W-1:0]  exp_evicted;
    } t_dir_row;

    // Receiver behavior: always ready, ready most of the time, or fully blocked.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_CHOPPY,
        RX_BLOCKED
    } t_rx_mode;

    localparam int DIR_ROWS       = 24;
    localparam int IDLE_LIMIT     = 20000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASES         = 8;

    logic                         i_clk               = 1'b0;
    logic                         i_rst_n             = 1'b0;
    logic                         i_cfg_we            = 1'b0;
    logic [pntr_pkg::CFG_W-1:0]   i_cfg_data          = '0;
    logic                         i_in_valid          = 1'b0;
    logic                         o_in_ready;
    logic [pntr_pkg::REAL_W-1:0]  i_real_page         = '0;
    logic [pntr_pkg::SLOT_W-1:0]  i_slot              = '0;
    logic                         o_out_valid;
    logic                         i_out_ready         = 1'b0;
    logic [pntr_pkg::SHORT_W-1:0] o_short_page;
    logic                         o_allocated;
    logic [pntr_pkg::REAL_W-1:0]  o_evicted_real_page;

    page_number_translation_recycler_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_real_page         (i_real_page),
        .i_slot              (i_slot),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_short_page        (o_short_page),
        .o_allocated         (o_allocated),
        .o_evicted_real_page (o_evicted_real_page)
    );

    // 8 ns clock period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction state. These mirror the block's translation tables, the
    // recycling cursor, the per-slot pins and the page_count register.
    // ------------------------------------------------------------------
    logic [pntr_pkg::SHORT_W-1:0] fwd_map [pntr_pkg::MAX_REAL_PAGES];
    logic [pntr_pkg::REAL_W-1:0]  rev_map [pntr_pkg::SHORT_PAGE_COUNT];
    logic [pntr_pkg::SHORT_W-1:0] slot_pin [pntr_pkg::SLOT_COUNT];
    int                           alloc_cursor;
    logic [pntr_pkg::CFG_W-1:0]   cur_page_count;

    t_page_result       expected_translations [$];
    int                 error_count = 0;

    // Sender burst bookkeeping and a small ring of recently used real pages,
    // which is what makes hits common in big mode.
    int                          burst_left = 0;
    logic [pntr_pkg::REAL_W-1:0] recent_pages [16];
    int                          recent_wr = 0;

    // Both tables go back to identity and the cursor to zero. Slot pins survive.
    task automatic init_translation_tables();
        for (int i = 0; i < pntr_pkg::MAX_REAL_PAGES; i++) begin
            fwd_map[i] = (i < pntr_pkg::SHORT_PAGE_COUNT) ? pntr_pkg::SHORT_W'(i)
                                                          : pntr_pkg::NO_PAGE;
        end
        for (int i = 0; i < pntr_pkg::SHORT_PAGE_COUNT; i++) begin
            rev_map[i] = pntr_pkg::REAL_W'(i % pntr_pkg::MAX_REAL_PAGES);
        end
        alloc_cursor = 0;
    endtask

    // Works out the result of one accepted request and updates the state.
    task automatic predict_translation(input logic [pntr_pkg::REAL_W-1:0] rp,
                                       input logic [pntr_pkg::SLOT_W-1:0] sl,
                                       output t_page_result res);
        logic [pntr_pkg::REAL_W-1:0] r;
        logic [pntr_pkg::REAL_W-1:0] old;
        int                v;
        int                tries;
        bit                found;
        bit                pinned;
        res = '0;
        if (cur_page_count >= pntr_pkg::BIG_LOW && cur_page_count <= pntr_pkg::BIG_HIGH) begin
            r = pntr_pkg::REAL_W'(rp % pntr_pkg::MAX_REAL_PAGES);
            res.short_page = fwd_map[r];
            if (res.short_page == pntr_pkg::NO_PAGE
                    || res.short_page >= pntr_pkg::SHORT_PAGE_COUNT) begin
                // Miss: walk the cursor past every number that a slot holds.
                v     = alloc_cursor;
                tries = 0;
                found = 1'b0;
                while (tries < pntr_pkg::SHORT_PAGE_COUNT && !found) begin
                    v = alloc_cursor;
                    alloc_cursor = (alloc_cursor + 1 >= pntr_pkg::SHORT_PAGE_COUNT)
                                 ? 0 : alloc_cursor + 1;
                    tries++;
                    pinned = 1'b0;
                    for (int s = 0; s < pntr_pkg::SLOT_COUNT; s++) begin
                        if (slot_pin[s] == pntr_pkg::SHORT_W'(v)) begin
                            pinned = 1'b1;
                        end
                    end
                    found = !pinned;
                end
                // With every number pinned, the one under the cursor is taken anyway.
                if (!found) begin
                    v = alloc_cursor;
                    alloc_cursor = (alloc_cursor + 1 >= pntr_pkg::SHORT_PAGE_COUNT)
                                 ? 0 : alloc_cursor + 1;
                end
                old          = pntr_pkg::REAL_W'(rev_map[v] % pntr_pkg::MAX_REAL_PAGES);
                fwd_map[old] = pntr_pkg::NO_PAGE;
                rev_map[v]   = r;
                fwd_map[r]   = pntr_pkg::SHORT_W'(v);
                res.short_page = pntr_pkg::SHORT_W'(v);
                res.allocated  = 1'b1;
                res.evicted    = old;
            end
        end else begin
            // Pass-through: the low byte of the real page is the short page.
            res.short_page = rp[pntr_pkg::SHORT_W-1:0];
        end
        if (sl < pntr_pkg::SLOT_COUNT) begin
            slot_pin[sl] = res.short_page;
        end
    endtask

    task automatic report_error(input string msg);
        $display("%0t ns ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Presents one request beat and waits for it to be taken. Valid stays high
    // into the next request unless the current burst has ended, in which case
    // the sender backs off for a random gap.
    task automatic send_item(input logic [pntr_pkg::REAL_W-1:0] rp,
                             input logic [pntr_pkg::SLOT_W-1:0] sl,
                             input bit use_typed, input t_page_result typed_res);
        t_page_result res;
        i_in_valid  <= 1'b1;
        i_real_page <= rp;
        i_slot      <= sl;
        do begin
            @(posedge i_clk);
        end while (!(i_in_valid && o_in_ready));
        predict_translation(rp, sl, res);
        expected_translations.push_back(use_typed ? typed_res : res);
        recent_pages[recent_wr] = rp;
        recent_wr = (recent_wr + 1) % 16;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            // Now and then a long burst with no idle cycle at all.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Stops the sender and waits until every expected result has been taken,
    // then lets the block settle so that it is fully idle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_translations.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The write starts a table clearing pass inside the block; the sender
    // simply waits for ready afterwards.
    task automatic write_page_count(input logic [pntr_pkg::CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_page_count = value;
        init_translation_tables();
    endtask

    // ------------------------------------------------------------------
    // Directed table. Typed rows carry a result that is obvious at a glance:
    // pass-through values, hits on the identity map, extremes of the fields.
    // Predicted rows are recycles and hits whose outcome depends on cursor and pins.
    // ------------------------------------------------------------------
    t_dir_row directed_rows [DIR_ROWS] = '{
        // Pass-through after reset.
        '{ROW_TYPED,     13'd0,    11'd0,    3'd0, 8'd0,   1'b0, 11'd0},
        '{ROW_TYPED,     13'd0,    11'd2047, 3'd7, 8'd255, 1'b0, 11'd0},
        '{ROW_TYPED,     13'd0,    11'd1365, 3'd5, 8'd85,  1'b0, 11'd0},
        '{ROW_TYPED,     13'd0,    11'd682,  3'd2, 8'd170, 1'b0, 11'd0},
        // Lowest big mode count: identity hits at both ends of the short range.
        '{ROW_CFG,       13'd257,  11'd0,    3'd0, 8'd0,   1'b0, 11'd0},
        '{ROW_TYPED,     13'd0,    11'd0,    3'd0, 8'd0,   1'b0, 11'd0},
        '{ROW_TYPED,     13'd0,    11'd254,  3'd1, 8'd254, 1'b0, 11'd0},
        // First miss must skip short number 0, which slot 0 now pins.
        '{ROW_PREDICTED, 13'd0,    11'd255,  3'd2, 8'd0,   1'b0, 11'd0},
        '{ROW_PREDICTED, 13'd0,    11'd2047, 3'd3, 8'd0,   1'b0, 11'd0},
        // Page 1 lost its number above, so it misses now.
        '{ROW_PREDICTED, 13'd0,    11'd1,    3'd4, 8'd0,   1'b0, 11'd0},
        '{ROW_PREDICTED, 13'd0,    11'd1365, 3'd6, 8'd0,   1'b0, 11'd0},
        '{ROW_PREDICTED, 13'd0,    11'd255,  3'd7, 8'd0,   1'b0, 11'd0},
        // Highest big mode count.
        '{ROW_CFG,       13'd2048, 11'd0,    3'd0, 8'd0,   1'b0, 11'd0},
        '{ROW_TYPED,     13'd0,    11'd100,  3'd0, 8'd100, 1'b0, 11'd0},
        '{ROW_PREDICTED, 13'd0,    11'd1024, 3'd1, 8'd0,   1'b0, 11'd0},
        '{ROW_PREDICTED, 13'd0,    11'd2046, 3'd2, 8'd0,   1'b0, 11'd0},
        // Just below and just above the big mode window, then 4096 and zero.
        '{ROW_CFG,       13'd256,  11'd0,    3'd0, 8'd0,   1'b0, 11'd0},
        '{ROW_TYPED,     13'd0,    11'd300,  3'd3, 8'd44,  1'b0, 11'd0},
        '{ROW_CFG,       13'd2049, 11'd0,    3'd0, 8'd0,   1'b0, 11'd0},
        '{ROW_TYPED,     13'd0,    11'd2047, 3'd4, 8'd255, 1'b0, 11'd0},
        '{ROW_CFG,       13'd4096, 11'd0,    3'd0, 8'd0,   1'b0, 11'd0},
        '{ROW_TYPED,     13'd0,    11'd1365, 3'd5, 8'd85,  1'b0, 11'd0},
        '{ROW_CFG,       13'd0,    11'd0,    3'd0, 8'd0,   1'b0, 11'd0},
        '{ROW_TYPED,     13'd0,    11'd513,  3'd6, 8'd1,   1'b0, 11'd0}
    };

    // ------------------------------------------------------------------
    // Receiver: stalls follow a pattern of modes that last a random number
    // of cycles. Every accepted result beat is checked against the oldest
    // expectation here.
    // ------------------------------------------------------------------
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;

    always @(posedge i_clk) begin
        t_page_result want;
        if (o_out_valid && i_out_ready) begin
            if (expected_translations.size() == 0) begin
                report_error($sformatf("result beat with nothing expected: short %0d",
                                       o_short_page));
            end else begin
                want = expected_translations.pop_front();
                if (o_short_page !== want.short_page) begin
                    report_error($sformatf("short_page got %0d want %0d",
                                           o_short_page, want.short_page));
                end
                if (o_allocated !== want.allocated) begin
                    report_error($sformatf("allocated got %0d want %0d",
                                           o_allocated, want.allocated));
                end
                if (o_evicted_real_page !== want.evicted) begin
                    report_error($sformatf("evicted_real_page got %0d want %0d",
                                           o_evicted_real_page, want.evicted));
                end
            end
        end
        if (rx_left <= 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    rx_mode = RX_FREE;
                    rx_left = $urandom_range(10, 60);
                end
                1: begin
                    rx_mode = RX_CHOPPY;
                    rx_left = $urandom_range(10, 60);
                end
                default: begin
                    rx_mode = RX_BLOCKED;
                    rx_left = $urandom_range(1, 12);
                end
            endcase
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:    i_out_ready <= 1'b1;
            RX_CHOPPY:  i_out_ready <= ($urandom_range(0, 3) != 0);
            default:    i_out_ready <= 1'b0;
        endcase
    end

    // Watchdog: nothing is accepted during the clearing pass after a page_count
    // write, so the limit sits well above the length of that pass.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, then random phases over a range
    // of page_count settings.
    // ------------------------------------------------------------------
    initial begin
        t_page_result                typed;
        logic [pntr_pkg::CFG_W-1:0]  phase_counts [PHASES];
        int                          phase_items  [PHASES];
        logic [pntr_pkg::REAL_W-1:0] rp;
        logic [pntr_pkg::SLOT_W-1:0] sl;
        int                          pick;

        cur_page_count = '0;
        init_translation_tables();
        for (int s = 0; s < pntr_pkg::SLOT_COUNT; s++) begin
            slot_pin[s] = pntr_pkg::NO_PAGE;
        end
        for (int i = 0; i < 16; i++) begin
            recent_pages[i] = pntr_pkg::REAL_W'(i);
        end
        burst_left = $urandom_range(1, 12);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_page_count(directed_rows[i].cfg_value);
            end else begin
                typed.short_page = directed_rows[i].exp_short;
                typed.allocated  = directed_rows[i].exp_alloc;
                typed.evicted    = directed_rows[i].exp_evicted;
                send_item(directed_rows[i].real_pg, directed_rows[i].slot_no,
                          directed_rows[i].kind == ROW_TYPED, typed);
            end
        end

        // Big mode phases are long so that the cursor wraps and runs into
        // pinned numbers; pass-through phases are short.
        phase_counts[0] = 13'd257;                     phase_items[0] = 500;
        phase_counts[1] = 13'd0;                       phase_items[1] = 60;
        phase_counts[2] = 13'd2048;                    phase_items[2] = 420;
        phase_counts[3] = 13'd256;                     phase_items[3] = 60;
        phase_counts[4] = pntr_pkg::CFG_W'($urandom_range(258, 2047));
        phase_items[4]  = 300;
        phase_counts[5] = 13'd4096;                    phase_items[5] = 60;
        phase_counts[6] = pntr_pkg::CFG_W'($urandom_range(2049, 4095));
        phase_items[6]  = 60;
        phase_counts[7] = 13'd257;                     phase_items[7] = 390;

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_page_count(phase_counts[p]);
            for (int n = 0; n < phase_items[p]; n++) begin
                // Halfway through the widest big mode phase the sender holds
                // off until every outstanding result has come back.
                if (p == 2 && n == phase_items[p] / 2) begin
                    drain_results();
                end
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    rp = pntr_pkg::REAL_W'($urandom_range(0, pntr_pkg::MAX_REAL_PAGES - 1));
                end else if (pick < 82) begin
                    rp = recent_pages[$urandom_range(0, 15)];
                end else begin
                    // Low pages hit the identity map and so pin low numbers,
                    // which later misses have to step over.
                    rp = pntr_pkg::REAL_W'($urandom_range(0, 15));
                end
                sl = pntr_pkg::SLOT_W'($urandom_range(0, pntr_pkg::SLOT_COUNT - 1));
                send_item(rp, sl, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
